// File: src/shs_pkg.sv
// Shared types, constants and functions of the SHA-256 stream hasher.
// No dependencies; imported by shs_sched, shs_core and the top level.
package shs_pkg;

    localparam int unsigned WordW     = 32;
    localparam int unsigned NumWords  = 8;
    localparam int unsigned WinWords  = 16;
    localparam logic [7:0]  PadMark   = 8'h80;
    localparam logic [5:0]  FillLast  = 6'd63;
    localparam logic [5:0]  LenPos    = 6'd56;
    localparam logic [5:0]  RoundLast = 6'd63;
    localparam logic [2:0]  WordLast  = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_FINAL,
        S_PAD_MARK,
        S_PAD_ZERO,
        S_PAD_LEN,
        S_OUT
    } t_state;

    // schedule window control
    typedef struct packed {
        logic       shift_byte;
        logic [7:0] byte_val;
        logic       shift_word;
    } t_sched_ctl;

    // compression core control
    typedef struct packed {
        logic       load;
        logic       round;
        logic       final_add;
        logic       reset_iv;
        logic [5:0] rnd;
    } t_core_ctl;

    localparam logic [WordW-1:0] InitH [NumWords] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [WordW-1:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x,
                                              input int unsigned n);
        rotr = (x >> n) | (x << (WordW - n));
    endfunction

    function automatic logic [WordW-1:0] big_sig0(input logic [WordW-1:0] x);
        big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [WordW-1:0] big_sig1(input logic [WordW-1:0] x);
        big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [WordW-1:0] sml_sig0(input logic [WordW-1:0] x);
        sml_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [WordW-1:0] sml_sig1(input logic [WordW-1:0] x);
        sml_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// File: src/shs_if.sv
// Valid/ready channel interfaces: byte items in, digest word items out.
// Depends on nothing; widths follow the item fields.
interface shs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, msg_byte, byte_present, end_of_message, input ready);
    modport sink   (input valid, msg_byte, byte_present, end_of_message, output ready);
endinterface

interface shs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: src/shs_sched.sv
// Block buffer and message schedule: a 16-word window that takes bytes in
// and then shifts out W[t] one word per round. Depends on shs_pkg.
module shs_sched
    import shs_pkg::*;
(
    input  logic             i_clk,
    input  t_sched_ctl       i_ctl,
    output logic [WordW-1:0] o_w
);

    logic [WordW-1:0] r_win [WinWords];
    logic [WordW-1:0] n_sched;

    // W[t+16] from the window taps t, t+1, t+9, t+14
    always_comb begin
        n_sched = r_win[0] + sml_sig0(r_win[1]) + r_win[9] + sml_sig1(r_win[14]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_byte) begin
            for (int i = 0; i < WinWords - 1; i++) begin
                r_win[i] <= {r_win[i][WordW-9:0], r_win[i+1][WordW-1:WordW-8]};
            end
            r_win[WinWords-1] <= {r_win[WinWords-1][WordW-9:0], i_ctl.byte_val};
        end else if (i_ctl.shift_word) begin
            for (int i = 0; i < WinWords - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[WinWords-1] <= n_sched;
        end
    end

    assign o_w = r_win[0];

endmodule

// File: src/shs_core.sv
// Compression core: working variables a..h, one round per cycle while
// i_ctl.round is set, and the eight chaining words. Depends on shs_pkg.
module shs_core
    import shs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_core_ctl        i_ctl,
    input  logic [WordW-1:0] i_w,
    input  logic [2:0]       i_sel,
    output logic [WordW-1:0] o_word
);

    logic [WordW-1:0] r_chain [NumWords];
    logic [WordW-1:0] r_v     [NumWords];
    logic [WordW-1:0] n_t1;
    logic [WordW-1:0] n_t2;

    always_comb begin
        n_t1 = r_v[7] + big_sig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + RoundK[i_ctl.rnd] + i_w;
        n_t2 = big_sig0(r_v[0])
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_v <= r_chain;
        end else if (i_ctl.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + n_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= n_t1 + n_t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.reset_iv) begin
            r_chain <= InitH;
        end else if (i_ctl.final_add) begin
            for (int i = 0; i < NumWords; i++) begin
                r_chain[i] <= r_chain[i] + r_v[i];
            end
        end
    end

    assign o_word = r_chain[i_sel];

endmodule

// File: src/sha256_stream_hasher_top.sv
// Top level of the SHA-256 stream hasher: sequencer, length counter and
// padding. Depends on shs_pkg, shs_if, shs_sched and shs_core.
//
// Usage:
//  - i_in carries one item per message byte (byte_present) and an end mark
//    (end_of_message); an item with neither changes nothing.
//  - o_out carries the eight digest words, H0 first, word_index 0..7,
//    last_word set on the eighth.
//  - A byte item is taken while the sequencer is idle. The item that fills a
//    64-byte block then starts a compression: 64 rounds on the shared round
//    unit, then a final step that folds the result into the chaining words.
//  - An end mark pads one byte per cycle (mark, zeros up to byte 56, an idle
//    step at byte 56, eight length bytes), pausing for the compression of
//    each block that fills (one or two), then the digest words, one per
//    cycle while the receiver is ready.
//  - No byte is taken while a filled block is being compressed.
//  - i_in.ready is high only while the sequencer is idle; the block works on
//    one item at a time.
//  - If the receiver stalls, the current digest word is held until taken;
//    after the last word the chaining state returns to the initial values.
//  - Reset (i_rst_n low, synchronous) loads the initial hash values and
//    clears the byte count, the bit length and the sequencer.
module sha256_stream_hasher_top
    import shs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    shs_in_if.sink    i_in,
    shs_out_if.source o_out
);

    t_state     r_state, n_state;
    logic [5:0] r_fill, n_fill;       // bytes in the current block
    logic [63:0] r_bits, n_bits;      // message length in bits
    logic [5:0] r_rnd, n_rnd;
    logic [2:0] r_len, n_len;         // length byte counter
    logic [2:0] r_oidx, n_oidx;       // digest word counter
    logic       r_eom, n_eom;         // end mark seen, padding pending
    logic       r_mark, n_mark;       // 0x80 already placed
    logic       r_lend, n_lend;       // length placed, last compression running

    logic       in_acc;
    logic       out_acc;
    t_sched_ctl sched_ctl;
    t_core_ctl  core_ctl;
    logic [WordW-1:0] sched_w;
    logic [WordW-1:0] chain_word;

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.byte_present && r_fill == FillLast) begin
                        n_state = S_ROUND;
                    end else if (i_in.end_of_message) begin
                        n_state = S_PAD_MARK;
                    end
                end
            end
            S_ROUND: begin
                if (r_rnd == RoundLast) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                priority if (r_lend) begin
                    n_state = S_OUT;
                end else if (r_eom && !r_mark) begin
                    n_state = S_PAD_MARK;
                end else if (r_eom) begin
                    n_state = S_PAD_ZERO;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PAD_MARK: begin
                n_state = (r_fill == FillLast) ? S_ROUND : S_PAD_ZERO;
            end
            S_PAD_ZERO: begin
                priority if (r_fill == LenPos) begin
                    n_state = S_PAD_LEN;
                end else if (r_fill == FillLast) begin
                    n_state = S_ROUND;
                end else begin
                    n_state = S_PAD_ZERO;
                end
            end
            S_PAD_LEN: begin
                if (r_len == WordLast) begin
                    n_state = S_ROUND;
                end
            end
            S_OUT: begin
                if (out_acc && r_oidx == WordLast) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and counters
    always_comb begin
        n_fill = r_fill;
        n_bits = r_bits;
        n_rnd  = r_rnd;
        n_len  = r_len;
        n_oidx = r_oidx;
        n_eom  = r_eom;
        n_mark = r_mark;
        n_lend = r_lend;
        sched_ctl = '0;
        core_ctl  = '0;
        core_ctl.rnd = r_rnd;
        core_ctl.load = (n_state == S_ROUND) && (r_state != S_ROUND);
        i_in.ready  = 1'b0;
        o_out.valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (in_acc) begin
                    n_eom = i_in.end_of_message;
                    if (i_in.byte_present) begin
                        sched_ctl.shift_byte = 1'b1;
                        sched_ctl.byte_val   = i_in.msg_byte;
                        n_fill = r_fill + 6'd1;
                        n_bits = r_bits + 64'd8;
                    end
                end
            end
            S_ROUND: begin
                core_ctl.round       = 1'b1;
                sched_ctl.shift_word = 1'b1;
                n_rnd = r_rnd + 6'd1;
            end
            S_FINAL: begin
                core_ctl.final_add = 1'b1;
            end
            S_PAD_MARK: begin
                sched_ctl.shift_byte = 1'b1;
                sched_ctl.byte_val   = PadMark;
                n_fill = r_fill + 6'd1;
                n_mark = 1'b1;
            end
            S_PAD_ZERO: begin
                if (r_fill != LenPos) begin
                    sched_ctl.shift_byte = 1'b1;
                    n_fill = r_fill + 6'd1;
                end
            end
            S_PAD_LEN: begin
                // length goes out big-endian, top byte first
                sched_ctl.shift_byte = 1'b1;
                sched_ctl.byte_val   = r_bits[63:56];
                n_bits = {r_bits[55:0], 8'h00};
                n_fill = r_fill + 6'd1;
                n_len  = r_len + 3'd1;
                if (r_len == WordLast) begin
                    n_lend = 1'b1;
                end
            end
            S_OUT: begin
                o_out.valid = 1'b1;
                if (out_acc) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == WordLast) begin
                        core_ctl.reset_iv = 1'b1;
                        n_bits = '0;
                        n_eom  = 1'b0;
                        n_mark = 1'b0;
                        n_lend = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_bits  <= '0;
            r_rnd   <= '0;
            r_len   <= '0;
            r_oidx  <= '0;
            r_eom   <= 1'b0;
            r_mark  <= 1'b0;
            r_lend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_bits  <= n_bits;
            r_rnd   <= n_rnd;
            r_len   <= n_len;
            r_oidx  <= n_oidx;
            r_eom   <= n_eom;
            r_mark  <= n_mark;
            r_lend  <= n_lend;
        end
    end

    shs_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (sched_ctl),
        .o_w   (sched_w)
    );

    shs_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .i_w     (sched_w),
        .i_sel   (r_oidx),
        .o_word  (chain_word)
    );

    assign o_out.digest_word = chain_word;
    assign o_out.word_index  = r_oidx;
    assign o_out.last_word   = (r_oidx == WordLast);

endmodule

// File: tb/shs_checker.sv
`timescale 1ns / 100ps
// Digest checker for the SHA-256 stream hasher: watches both channels, keeps its
// own hash state and compares each digest word with the predicted one.
// Depends on shs_if (channel interfaces) only.
module shs_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    shs_in_if    i_in_ch,
    shs_out_if   i_out_ch,
    output int   o_err_count,
    output int   o_pending
);

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_item_t;

    localparam logic [31:0] IvWords [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] KTab [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic [31:0]  chain_q [8];
    logic [7:0]   blk_q [64];
    logic [5:0]   fill_q;
    logic [63:0]  nbits_q;
    digest_item_t digest_exp_q [$];

    int mism_cnt = 0;
    int exp_cnt  = 0;

    assign o_err_count = mism_cnt;
    assign o_pending   = exp_cnt;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        logic [63:0] dbl;
        dbl = {x, x} >> n;
        return dbl[31:0];
    endfunction

    function automatic logic [31:0] sum_a(input logic [31:0] x);
        return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
    endfunction

    function automatic logic [31:0] sum_e(input logic [31:0] x);
        return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
    endfunction

    function automatic logic [31:0] mix_lo(input logic [31:0] x);
        return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] mix_hi(input logic [31:0] x);
        return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mism_cnt++;
    endtask

    // one 64-round compression of blk_q into chain_q
    task automatic fold_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        int i;
        for (i = 0; i < 16; i++) begin
            w[i] = {blk_q[4*i], blk_q[4*i+1], blk_q[4*i+2], blk_q[4*i+3]};
        end
        for (i = 16; i < 64; i++) begin
            w[i] = w[i-16] + mix_lo(w[i-15]) + w[i-7] + mix_hi(w[i-2]);
        end
        a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3];
        e = chain_q[4]; f = chain_q[5]; g = chain_q[6]; h = chain_q[7];
        for (i = 0; i < 64; i++) begin
            t1 = h + sum_e(e) + ((e & f) ^ (~e & g)) + KTab[i] + w[i];
            t2 = sum_a(a) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d;
        chain_q[4] += e; chain_q[5] += f; chain_q[6] += g; chain_q[7] += h;
    endtask

    task automatic restart_hash();
        int i;
        for (i = 0; i < 8; i++) chain_q[i] = IvWords[i];
        fill_q  = '0;
        nbits_q = '0;
    endtask

    // absorb one accepted item; an end mark pads and queues the eight words
    task automatic hash_item(input logic [7:0] b, input logic has_byte, input logic eom);
        int pos;
        int i;
        digest_item_t di;
        if (has_byte) begin
            blk_q[fill_q] = b;
            nbits_q += 64'd8;
            if (fill_q == 6'd63) begin
                fold_block();
                fill_q = '0;
            end else begin
                fill_q++;
            end
        end
        if (eom) begin
            pos = int'(fill_q);
            blk_q[pos] = 8'h80;
            pos++;
            if (pos > 56) begin
                while (pos < 64) begin
                    blk_q[pos] = 8'h00;
                    pos++;
                end
                fold_block();
                pos = 0;
            end
            while (pos < 56) begin
                blk_q[pos] = 8'h00;
                pos++;
            end
            for (i = 0; i < 8; i++) blk_q[63-i] = nbits_q[8*i +: 8];
            fold_block();
            for (i = 0; i < 8; i++) begin
                di.word = chain_q[i];
                di.idx  = 3'(i);
                di.last = (i == 7);
                digest_exp_q.push_back(di);
            end
            restart_hash();
        end
    endtask

    always @(posedge i_clk) begin
        digest_item_t got, want;
        if (!i_rst_n) begin
            restart_hash();
            digest_exp_q.delete();
        end else begin
            if (i_out_ch.valid && i_out_ch.ready) begin
                got.word = i_out_ch.digest_word;
                got.idx  = i_out_ch.word_index;
                got.last = i_out_ch.last_word;
                if (digest_exp_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected digest word %h idx %0d last %0b",
                                              got.word, got.idx, got.last));
                end else begin
                    want = digest_exp_q.pop_front();
                    if (got.word !== want.word || got.idx !== want.idx ||
                        got.last !== want.last) begin
                        report_mismatch($sformatf(
                            "word %h/%h idx %0d/%0d last %0b/%0b (got/exp)",
                            got.word, want.word, got.idx, want.idx, got.last, want.last));
                    end
                end
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                hash_item(i_in_ch.msg_byte, i_in_ch.byte_present, i_in_ch.end_of_message);
            end
        end
        exp_cnt = digest_exp_q.size();
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Top of the SHA-256 stream hasher testbench: clock, reset, item stimulus and
// receiver back-pressure; checking is done by shs_checker. Depends on shs_if.
module tb_top;

    // receiver hold-off length and quiet time after the last digest word
    localparam int HoldCycles  = 500;
    localparam int DrainCycles = 300;
    localparam int RandItems   = 260;

    logic i_clk;
    logic i_rst_n;

    shs_in_if  in_ch ();
    shs_out_if out_ch ();

    int n_err;
    int n_pending;

    // idling knobs, percent of cycles; one for the sender, one for the receiver
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // set by stimulus, cleared by the receiver once the hold-off is over
    logic hold_req = 1'b0;
    int   hold_cnt;

    // items that carry a byte or an end mark (ignored items not counted)
    int n_items = 0;
    int n_directed;
    int msg_len;
    int pick;

    sha256_stream_hasher_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    shs_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_ch     (in_ch),
        .i_out_ch    (out_ch),
        .o_err_count (n_err),
        .o_pending   (n_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop; a correct run needs only a small fraction of this.
    initial begin
        #10_000_000;
        $display("FAIL sha256_stream_hasher_top");
        $finish;
    end

    // Receiver: ready is redrawn every falling edge. A hold-off request keeps
    // ready low until hold_cnt reaches HoldCycles, so the hasher backs up and
    // drops i_in.ready while the sender keeps offering items.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < HoldCycles; hold_cnt++) begin
                    @(negedge i_clk);
                end
                hold_req = 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offer one item. Entered just after a rising edge; returns just after
    // the rising edge that accepted it. Valid stays high between back-to-back
    // items, so each falling edge carries a single update.
    task automatic send_item(input logic [7:0] b, input logic has_byte, input logic eom);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid          <= 1'b1;
        in_ch.msg_byte       <= b;
        in_ch.byte_present   <= has_byte;
        in_ch.end_of_message <= eom;
        do @(posedge i_clk); while (!in_ch.ready);
        if (has_byte || eom) n_items++;
    endtask

    // One message of n_bytes random bytes. The end mark rides on the last byte
    // or comes as its own byte-less item; ignored items are sprinkled in.
    task automatic send_message(input int n_bytes);
        int   k;
        logic end_on_byte;
        end_on_byte = (n_bytes != 0) && ($urandom_range(1) == 1);
        for (k = 0; k < n_bytes; k++) begin
            if ($urandom_range(9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, end_on_byte && (k == n_bytes - 1));
        end
        if (!end_on_byte) send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin
        in_ch.valid          = 1'b0;
        in_ch.msg_byte       = 8'h00;
        in_ch.byte_present   = 1'b0;
        in_ch.end_of_message = 1'b0;
        i_rst_n              = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, no idling.
        // item with neither byte nor end mark: must change nothing
        send_item(8'h00, 1'b0, 1'b0);
        // end mark alone on a fresh hasher: empty message digest
        send_item(8'hff, 1'b0, 1'b1);
        // "abc", end mark on the last byte
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        // single zero byte, end mark as a separate byte-less item
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h5a, 1'b0, 1'b1);
        // single 0xFF byte with end mark
        send_item(8'hff, 1'b1, 1'b1);
        // ignored item in the middle of a message; its byte must not count
        send_item(8'h12, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h34, 1'b1, 1'b1);
        n_directed = n_items;

        // Random part. Start with a long receiver hold-off while the sender
        // streams, then step through the idling phases every 80 items.
        hold_req = 1'b1;
        while (n_items < n_directed + RandItems) begin
            case (((n_items - n_directed) / 80) % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            // mostly short messages, some right at the padding and block
            // boundaries (one vs. two pad blocks, block full at the end)
            pick = $urandom_range(99);
            if (pick < 55) begin
                msg_len = $urandom_range(8);
            end else if (pick < 85) begin
                case ($urandom_range(5))
                    0: msg_len = 55;
                    1: msg_len = 56;
                    2: msg_len = 57;
                    3: msg_len = 63;
                    4: msg_len = 64;
                    default: msg_len = 65;
                endcase
            end else begin
                msg_len = $urandom_range(54, 9);
            end
            send_message(msg_len);
        end

        @(negedge i_clk);
        in_ch.valid <= 1'b0;

        // wait for every predicted digest word, then watch for strays
        while (n_pending != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);

        if (n_err == 0 && n_pending == 0) begin
            $display("PASS sha256_stream_hasher_top");
        end else begin
            $display("FAIL sha256_stream_hasher_top");
        end
        $finish;
    end

endmodule
